@@ design/pfr_pkg.sv @@
// Package for the page frame replacement unit: sizes, codes, frame entry and RAM request types.
// No dependencies; every other design file refers to it by scoped names.
package pfr_pkg;

   localparam int FRAMES     = 64;
   localparam int IDX_W      = $clog2(FRAMES);
   localparam int CNT_W      = $clog2(FRAMES + 1);
   localparam int PID_W      = 16;
   localparam int PAGE_W     = 16;
   localparam int SWAP_W     = 20;
   localparam int TIME_W     = 32;
   localparam int FIDX_W     = 6;
   localparam int FIU_W      = 7;
   localparam int FIU_RESET  = 64;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   typedef enum logic {
      KIND_LOAD      = 1'b0,
      KIND_REFERENCE = 1'b1
   } kind_type;

   typedef enum logic {
      POLICY_FIFO = 1'b0,
      POLICY_LRU  = 1'b1
   } policy_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REPLACEMENT_POLICY = 1'b0,
      CSR_FRAMES_IN_USE      = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [PID_W-1:0]  owner;
      logic [PAGE_W-1:0] page;
      logic [SWAP_W-1:0] swap;
      logic              dirty;
      logic [TIME_W-1:0] load_time;
      logic [TIME_W-1:0] use_time;
   } frame_entry_type;

   typedef struct packed {
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      frame_entry_type  wr_data;
   } ram_req_type;

endpackage

@@ design/pfr_channels.sv @@
// Valid/ready channel interfaces for request and response transactions.
// Depends on pfr_pkg for field widths.
interface pfr_req_if;
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic [pfr_pkg::PID_W-1:0]  process_id;
   logic [pfr_pkg::PAGE_W-1:0] page_number;
   logic [pfr_pkg::SWAP_W-1:0] swap_slot;
   logic                       is_write;

   modport source (output valid, kind, process_id, page_number, swap_slot, is_write,
                   input ready);
   modport sink (input valid, kind, process_id, page_number, swap_slot, is_write,
                 output ready);
endinterface

interface pfr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       hit;
   logic [pfr_pkg::FIDX_W-1:0] frame_index;
   logic                       replaced;
   logic [pfr_pkg::PID_W-1:0]  victim_process;
   logic [pfr_pkg::PAGE_W-1:0] victim_page;
   logic [pfr_pkg::SWAP_W-1:0] victim_swap_slot;
   logic                       write_back;

   modport source (output valid, hit, frame_index, replaced, victim_process, victim_page,
                   victim_swap_slot, write_back, input ready);
   modport sink (input valid, hit, frame_index, replaced, victim_process, victim_page,
                 victim_swap_slot, write_back, output ready);
endinterface

@@ design/pfr_frame_ram.sv @@
// Frame table RAM: one write port, one read port with registered read data.
// Depends on pfr_pkg for the entry and request types.
module pfr_frame_ram (
   input  logic                     clock,
   input  pfr_pkg::ram_req_type     ram_req,
   output pfr_pkg::frame_entry_type rd_data
);

   pfr_pkg::frame_entry_type frame_mem [pfr_pkg::FRAMES];
   pfr_pkg::frame_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         frame_mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      rd_data_ff <= frame_mem[ram_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/pfr_ctrl.sv @@
// Scan sequencer: walks the frame RAM, picks free/oldest/matching frame, writes back, responds.
// Depends on pfr_pkg, pfr_channels; drives pfr_frame_ram through a ram_req_type struct.
module pfr_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          policy,
   input  logic [pfr_pkg::CNT_W-1:0]     n_active,
   pfr_req_if.sink                       req_chan,
   pfr_rsp_if.source                     rsp_chan,
   output pfr_pkg::ram_req_type          ram_req,
   input  pfr_pkg::frame_entry_type      ram_rdata
);

   pfr_pkg::state_type state_ff, state_in;

   // request payload
   logic                       kind_ff, kind_in;
   logic [pfr_pkg::PID_W-1:0]  pid_ff, pid_in;
   logic [pfr_pkg::PAGE_W-1:0] page_ff, page_in;
   logic [pfr_pkg::SWAP_W-1:0] slot_ff, slot_in;
   logic                       wr_ff, wr_in;

   // scan pipeline
   logic [pfr_pkg::CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic                       ev_vld_ff, ev_vld_in;
   logic [pfr_pkg::IDX_W-1:0]  ev_idx_ff, ev_idx_in;
   logic                       found_ff, found_in;
   logic [pfr_pkg::IDX_W-1:0]  sel_idx_ff, sel_idx_in;
   pfr_pkg::frame_entry_type   sel_entry_ff, sel_entry_in;
   logic [pfr_pkg::TIME_W-1:0] best_age_ff, best_age_in;

   logic [pfr_pkg::FRAMES-1:0] occupied_ff, occupied_in;
   logic [pfr_pkg::TIME_W-1:0] event_clock_ff, event_clock_in;

   // response register
   logic                       rsp_vld_ff, rsp_vld_in;
   logic                       hit_ff, hit_in;
   logic [pfr_pkg::FIDX_W-1:0] fidx_ff, fidx_in;
   logic                       replaced_ff, replaced_in;
   logic [pfr_pkg::PID_W-1:0]  vproc_ff, vproc_in;
   logic [pfr_pkg::PAGE_W-1:0] vpage_ff, vpage_in;
   logic [pfr_pkg::SWAP_W-1:0] vswap_ff, vswap_in;
   logic                       wback_ff, wback_in;

   logic                       accept, issue, eval, occ, is_load, is_last, match;
   logic                       free_hit, older, ref_hit, scan_done, out_free, finish, evict;
   logic [pfr_pkg::TIME_W-1:0] stamp, age;

   assign accept   = req_chan.valid && req_chan.ready;
   assign is_load  = (kind_ff == pfr_pkg::KIND_LOAD);
   assign issue    = (state_ff == pfr_pkg::ST_SCAN) && (rd_idx_ff < n_active);
   assign eval     = (state_ff == pfr_pkg::ST_SCAN) && ev_vld_ff;
   assign occ      = occupied_ff[ev_idx_ff];
   assign stamp    = (policy == pfr_pkg::POLICY_LRU) ? ram_rdata.use_time : ram_rdata.load_time;
   assign age      = event_clock_ff - stamp;
   assign is_last  = (pfr_pkg::CNT_W'(ev_idx_ff) + pfr_pkg::CNT_W'(1)) == n_active;
   assign match    = occ && (ram_rdata.owner == pid_ff) && (ram_rdata.page == page_ff);
   assign free_hit = eval && is_load && !occ;
   // lowest index wins ties: strict compare, first frame always taken
   assign older    = eval && is_load && occ && ((ev_idx_ff == '0) || (age > best_age_ff));
   assign ref_hit  = eval && !is_load && match;
   assign scan_done = free_hit || ref_hit || (eval && is_last);
   assign out_free = !rsp_vld_ff || rsp_chan.ready;
   assign finish   = (state_ff == pfr_pkg::ST_FINISH) && out_free;
   assign evict    = is_load && !found_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfr_pkg::ST_IDLE: begin
            if (accept) state_in = pfr_pkg::ST_SCAN;
         end
         pfr_pkg::ST_SCAN: begin
            if (scan_done) state_in = pfr_pkg::ST_FINISH;
         end
         pfr_pkg::ST_FINISH: begin
            if (finish) state_in = pfr_pkg::ST_IDLE;
         end
         default: state_in = pfr_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      kind_in        = kind_ff;
      pid_in         = pid_ff;
      page_in        = page_ff;
      slot_in        = slot_ff;
      wr_in          = wr_ff;
      rd_idx_in      = rd_idx_ff;
      ev_vld_in      = ev_vld_ff;
      ev_idx_in      = ev_idx_ff;
      found_in       = found_ff;
      sel_idx_in     = sel_idx_ff;
      sel_entry_in   = sel_entry_ff;
      best_age_in    = best_age_ff;
      occupied_in    = occupied_ff;
      event_clock_in = event_clock_ff;
      rsp_vld_in     = rsp_vld_ff;
      hit_in         = hit_ff;
      fidx_in        = fidx_ff;
      replaced_in    = replaced_ff;
      vproc_in       = vproc_ff;
      vpage_in       = vpage_ff;
      vswap_in       = vswap_ff;
      wback_in       = wback_ff;

      ram_req.rd_addr = rd_idx_ff[pfr_pkg::IDX_W-1:0];
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = sel_idx_ff;
      ram_req.wr_data = sel_entry_ff;

      if (accept) begin
         kind_in     = req_chan.kind;
         pid_in      = req_chan.process_id;
         page_in     = req_chan.page_number;
         slot_in     = req_chan.swap_slot;
         wr_in       = req_chan.is_write;
         rd_idx_in   = '0;
         ev_vld_in   = 1'b0;
         found_in    = 1'b0;
         best_age_in = '0;
      end

      if (state_ff == pfr_pkg::ST_SCAN) begin
         ev_vld_in = issue;
         ev_idx_in = rd_idx_ff[pfr_pkg::IDX_W-1:0];
         if (issue) rd_idx_in = rd_idx_ff + pfr_pkg::CNT_W'(1);
         if (free_hit || ref_hit) begin
            found_in     = 1'b1;
            sel_idx_in   = ev_idx_ff;
            sel_entry_in = ram_rdata;
         end
         if (older) begin
            best_age_in  = age;
            sel_idx_in   = ev_idx_ff;
            sel_entry_in = ram_rdata;
         end
      end

      // write-back: install new page clean, or refresh a referenced one
      if (is_load) begin
         ram_req.wr_data.owner     = pid_ff;
         ram_req.wr_data.page      = page_ff;
         ram_req.wr_data.swap      = slot_ff;
         ram_req.wr_data.dirty     = 1'b0;
         ram_req.wr_data.load_time = event_clock_ff;
         ram_req.wr_data.use_time  = event_clock_ff;
      end else begin
         ram_req.wr_data.use_time  = event_clock_ff;
         ram_req.wr_data.dirty     = sel_entry_ff.dirty | wr_ff;
      end

      if (rsp_chan.ready) rsp_vld_in = 1'b0;

      if (finish) begin
         ram_req.wr_en  = is_load || found_ff;
         if (is_load) occupied_in[sel_idx_ff] = 1'b1;
         event_clock_in = event_clock_ff + pfr_pkg::TIME_W'(1);
         rsp_vld_in     = 1'b1;
         hit_in         = is_load || found_ff;
         fidx_in        = (is_load || found_ff) ? pfr_pkg::FIDX_W'(sel_idx_ff) : '0;
         replaced_in    = evict;
         vproc_in       = evict ? sel_entry_ff.owner : '0;
         vpage_in       = evict ? sel_entry_ff.page : '0;
         vswap_in       = evict ? sel_entry_ff.swap : '0;
         wback_in       = evict && sel_entry_ff.dirty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pfr_pkg::ST_IDLE;
         ev_vld_ff      <= 1'b0;
         occupied_ff    <= '0;
         event_clock_ff <= '0;
         rsp_vld_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         ev_vld_ff      <= ev_vld_in;
         occupied_ff    <= occupied_in;
         event_clock_ff <= event_clock_in;
         rsp_vld_ff     <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      pid_ff       <= pid_in;
      page_ff      <= page_in;
      slot_ff      <= slot_in;
      wr_ff        <= wr_in;
      rd_idx_ff    <= rd_idx_in;
      ev_idx_ff    <= ev_idx_in;
      found_ff     <= found_in;
      sel_idx_ff   <= sel_idx_in;
      sel_entry_ff <= sel_entry_in;
      best_age_ff  <= best_age_in;
      hit_ff       <= hit_in;
      fidx_ff      <= fidx_in;
      replaced_ff  <= replaced_in;
      vproc_ff     <= vproc_in;
      vpage_ff     <= vpage_in;
      vswap_ff     <= vswap_in;
      wback_ff     <= wback_in;
   end

   assign req_chan.ready            = (state_ff == pfr_pkg::ST_IDLE);
   assign rsp_chan.valid            = rsp_vld_ff;
   assign rsp_chan.hit              = hit_ff;
   assign rsp_chan.frame_index      = fidx_ff;
   assign rsp_chan.replaced         = replaced_ff;
   assign rsp_chan.victim_process   = vproc_ff;
   assign rsp_chan.victim_page      = vpage_ff;
   assign rsp_chan.victim_swap_slot = vswap_ff;
   assign rsp_chan.write_back       = wback_ff;

endmodule

@@ design/page_frame_replacement_unit.sv @@
// Page frame replacement unit: FIFO/LRU frame table manager over a frame RAM with one read
// and one write port.
// Each load or reference is accepted only in the idle state; the scan then reads frames in index order
// until a free frame or a match is found, else up to the active count, one frame per cycle, and the
// finish state writes back and registers the response once the output register is free. A new
// request is taken only after that. Reset (synchronous): all frames free, event clock 0, policy
// FIFO, 64 frames active; no clearing pass.
module page_frame_replacement_unit (
   input  logic                              clock,
   input  logic                              reset,
   pfr_req_if.sink                           req_chan,
   pfr_rsp_if.source                         rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [pfr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pfr_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   // configuration registers
   logic                       policy_ff, policy_in;
   logic [pfr_pkg::FIU_W-1:0]  fiu_ff, fiu_in;
   logic [pfr_pkg::CNT_W-1:0]  n_active;

   pfr_pkg::ram_req_type       ram_req;
   pfr_pkg::frame_entry_type   ram_rdata;

   always_comb begin
      policy_in = policy_ff;
      fiu_in    = fiu_ff;
      if (csr_write_enable) begin
         case (pfr_pkg::csr_index_type'(csr_index))
            pfr_pkg::CSR_REPLACEMENT_POLICY: policy_in = csr_write_data[0];
            pfr_pkg::CSR_FRAMES_IN_USE:      fiu_in    = csr_write_data[pfr_pkg::FIU_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= pfr_pkg::POLICY_FIFO;
         fiu_ff    <= pfr_pkg::FIU_W'(pfr_pkg::FIU_RESET);
      end else begin
         policy_ff <= policy_in;
         fiu_ff    <= fiu_in;
      end
   end

   // active frame count: zero acts as one, anything past the table acts as the table size
   always_comb begin
      if (fiu_ff == '0) begin
         n_active = pfr_pkg::CNT_W'(1);
      end else if (32'(fiu_ff) > pfr_pkg::FRAMES) begin
         n_active = pfr_pkg::CNT_W'(pfr_pkg::FRAMES);
      end else begin
         n_active = pfr_pkg::CNT_W'(fiu_ff);
      end
   end

   pfr_frame_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rdata)
   );

   // scan sequencer owns the occupied bits, the event clock and the response register
   pfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .policy    (policy_ff),
      .n_active  (n_active),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

endmodule
